/* design/scp_pkg.sv */
// Package for the security context parser.
// Character codes, sizes and the structs passed between the parser, the bitmap store and the top level.
// No dependencies.
package scp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_CAT   = 8'h63;  // 'c'

  // Category bitmap
  localparam int CAT_COUNT = 255;
  localparam int IDX_W     = 8;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int WORDS     = 4;
  localparam int WA        = 2;
  localparam int NBANK     = 2;

  // Token accumulator
  localparam int TOK_MAX  = 4;
  localparam int TCW      = $clog2(TOK_MAX + 1);
  localparam int TNUM_W   = 10;
  localparam int TNUM_MAX = 1023;

  // String checks
  localparam logic [2:0] MIN_LEN    = 3'd5;
  localparam logic [2:0] NUM_COLONS = 3'd3;
  localparam logic [2:0] COLON_SAT  = 3'd4;

  typedef struct packed {
    logic       well_formed;
    logic [3:0] mls_type;
    logic [3:0] mls_level;
    logic [3:0] integrity_level;
  } fields_t;

  // Category bit to set
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } evt_t;

  // End of string, scalar results
  typedef struct packed {
    logic    vld;
    fields_t f;
  } fin_t;

  // One drained bitmap word with its scalar fields
  typedef struct packed {
    fields_t           f;
    logic [WA-1:0]     word_index;
    logic [WORD_W-1:0] data;
    logic              last;
  } dword_t;

endpackage

/* design/scp_if.sv */
// Handshake channels of the security context parser: byte input and result output.
// Depends on nothing.
interface scp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source(output valid, char_code, end_of_string, input ready);
  modport sink(input valid, char_code, end_of_string, output ready);
endinterface

interface scp_out_if;
  logic        valid;
  logic        ready;
  logic        well_formed;
  logic [3:0]  mls_type;
  logic [3:0]  mls_level;
  logic [3:0]  integrity_level;
  logic [1:0]  word_index;
  logic [63:0] category_word;
  logic        last_word;

  modport source(output valid, well_formed, mls_type, mls_level, integrity_level,
                 word_index, category_word, last_word, input ready);
  modport sink(input valid, well_formed, mls_type, mls_level, integrity_level,
               word_index, category_word, last_word, output ready);
endinterface

/* design/security_context_parser.sv */
// Security context parser: one byte a cycle in, four bitmap words per string out.
// A string's drain starts once its final byte is taken and the previous string is drained; it
// waits while a bit-set from one of the string's last two bytes is still being written. The
// four words follow one a cycle while out_chan.ready is high.
// Throughput: one byte per cycle; set by the bitmap RAM read-modify-write, one bit per byte.
// Input stalls only when both bitmap banks still hold strings waiting to be drained.
// Reset (rst_n, synchronous): clears the scanner, bank and drain control and the word valid bits;
// RAM contents are masked by the valid bits, so no clearing pass is needed.
module security_context_parser
  import scp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  scp_in_if.sink           in_chan,
  scp_out_if.source        out_chan
);

  // Byte accepted this cycle
  logic   acc;
  evt_t   evt;
  fin_t   fin;
  logic   bank_free;
  logic   wd_pend;
  dword_t wd;
  logic   take;

  // Output register
  logic   out_valid_r;
  dword_t out_r;

  assign in_chan.ready = bank_free;
  assign acc           = in_chan.valid && in_chan.ready;

  // Scanner: small registers updated on every accepted byte; emits at most one bit-set
  // and, on the final byte, the scalar fields already zeroed for malformed strings.
  scp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .char_code    (in_chan.char_code),
    .end_of_string(in_chan.end_of_string),
    .evt          (evt),
    .fin          (fin)
  );

  // Bitmap store: a string writes one bank while the other is drained, so the next
  // string starts straight away without a clear of the previous bitmap.
  scp_bitmap u_bitmap (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt      (evt),
    .fin      (fin),
    .take     (take),
    .bank_free(bank_free),
    .wd_pend  (wd_pend),
    .wd       (wd)
  );

  // Load a drained word when the output register is empty or being emptied
  assign take = wd_pend && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        out_r       <= wd;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.well_formed     = out_r.f.well_formed;
  assign out_chan.mls_type        = out_r.f.mls_type;
  assign out_chan.mls_level       = out_r.f.mls_level;
  assign out_chan.integrity_level = out_r.f.integrity_level;
  assign out_chan.word_index      = out_r.word_index;
  assign out_chan.category_word   = out_r.data;
  assign out_chan.last_word       = out_r.last;

endmodule

/* design/scp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first; rdata holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/scp_parse.sv */
// Per-byte scanner: colon and length counts, numeric fields, category token accumulator.
// Depends on scp_pkg.
module scp_parse
  import scp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] char_code,
  input  logic       end_of_string,
  output evt_t       evt,
  output fin_t       fin
);

  logic [2:0]        colon_r, colon_nxt;
  logic [2:0]        len_r, len_nxt;
  logic              pend_r, pend_nxt;
  logic [3:0]        type_r, type_nxt;
  logic [3:0]        lvl_r, lvl_nxt;
  logic [3:0]        integ_r, integ_nxt;
  logic [TCW-1:0]    tcnt_r, tcnt_nxt;
  logic [TNUM_W-1:0] tnum_r, tnum_nxt;
  logic              tval_r, tval_nxt;
  logic [IDX_W-1:0]  prev_r, prev_nxt;
  logic              pout_r, pout_nxt;

  logic              is_dig;
  logic [3:0]        dv;
  logic              close_tok;
  logic [13:0]       prod;

  always_comb begin
    is_dig    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    dv        = is_dig ? 4'(char_code - CHAR_ZERO) : 4'd1;
    prod      = 14'(tnum_r) * 14'd10 + 14'(dv);
    close_tok = 1'b0;

    colon_nxt = colon_r;
    len_nxt   = (len_r < MIN_LEN) ? len_r + 3'd1 : len_r;
    pend_nxt  = pend_r;
    type_nxt  = type_r;
    lvl_nxt   = lvl_r;
    integ_nxt = integ_r;
    tcnt_nxt  = tcnt_r;
    tnum_nxt  = tnum_r;
    tval_nxt  = tval_r;
    prev_nxt  = prev_r;
    pout_nxt  = pout_r;

    // first character of a numeric field
    if (pend_r) begin
      case (colon_r)
        3'd0:    type_nxt  = dv;
        3'd1:    lvl_nxt   = dv;
        3'd3:    integ_nxt = dv;
        default: ;
      endcase
      pend_nxt = 1'b0;
    end

    if (char_code == CHAR_COLON) begin
      close_tok = (colon_r == 3'd2) && (tcnt_r != '0);
      if (colon_r < COLON_SAT) begin
        colon_nxt = colon_r + 3'd1;
      end
      if (colon_nxt == NUM_COLONS) begin
        integ_nxt = 4'd1;  // empty integrity field reads as 1
      end
      pend_nxt = 1'b1;
    end else if (colon_r == 3'd2) begin
      if (char_code == CHAR_COMMA) begin
        close_tok = 1'b1;
      end else if (tcnt_r < TCW'(TOK_MAX)) begin
        if (tcnt_r == '0) begin
          tcnt_nxt = (char_code == CHAR_CAT) ? TCW'(1) : TCW'(TOK_MAX);
        end else if (is_dig) begin
          tnum_nxt = (prod > 14'(TNUM_MAX)) ? TNUM_W'(TNUM_MAX) : prod[TNUM_W-1:0];
          tval_nxt = 1'b1;
          tcnt_nxt = tcnt_r + TCW'(1);
        end else begin
          tcnt_nxt = TCW'(TOK_MAX);
        end
      end
    end

    // a failed token reuses the previous index
    if (close_tok) begin
      if (tval_r) begin
        if (tnum_r >= TNUM_W'(CAT_COUNT)) begin
          pout_nxt = 1'b1;
        end else begin
          pout_nxt = 1'b0;
          prev_nxt = tnum_r[IDX_W-1:0];
        end
      end
      tcnt_nxt = '0;
      tnum_nxt = '0;
      tval_nxt = 1'b0;
    end

    evt.vld = acc && close_tok && !pout_nxt && ({1'b0, prev_nxt} < 9'(CAT_COUNT));
    evt.idx = prev_nxt;

    fin.vld = acc && end_of_string;
    fin.f.well_formed = (len_nxt >= MIN_LEN) && (colon_nxt == NUM_COLONS);
    fin.f.mls_type        = fin.f.well_formed ? type_nxt  : 4'd0;
    fin.f.mls_level       = fin.f.well_formed ? lvl_nxt   : 4'd0;
    fin.f.integrity_level = fin.f.well_formed ? integ_nxt : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && end_of_string)) begin
      colon_r <= '0;
      len_r   <= '0;
      pend_r  <= 1'b1;
      type_r  <= '0;
      lvl_r   <= '0;
      integ_r <= '0;
      tcnt_r  <= '0;
      tnum_r  <= '0;
      tval_r  <= 1'b0;
      prev_r  <= '0;
      pout_r  <= 1'b0;
    end else if (acc) begin
      colon_r <= colon_nxt;
      len_r   <= len_nxt;
      pend_r  <= pend_nxt;
      type_r  <= type_nxt;
      lvl_r   <= lvl_nxt;
      integ_r <= integ_nxt;
      tcnt_r  <= tcnt_nxt;
      tnum_r  <= tnum_nxt;
      tval_r  <= tval_nxt;
      prev_r  <= prev_nxt;
      pout_r  <= pout_nxt;
    end
  end

endmodule

/* design/scp_bitmap.sv */
// Double-banked category bitmap: bit-set read-modify-write with forwarding, word valid bits,
// and the drain sequencer that reads a finished bank out word by word. Depends on scp_pkg, scp_ram.
module scp_bitmap
  import scp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  evt_t   evt,
  input  fin_t   fin,
  input  logic   take,
  output logic   bank_free,
  output logic   wd_pend,
  output dword_t wd
);

  logic                         cur_bank_r;
  logic [NBANK-1:0]             busy_r;
  logic [NBANK-1:0][WORDS-1:0]  wvld_r;
  fields_t                      fld_r [NBANK];

  logic                         s1_v_r, s1_bank_r;
  logic [IDX_W-1:0]             s1_idx_r;
  logic                         s2_v_r, s2_bank_r;
  logic [IDX_W-1:0]             s2_idx_r;
  logic                         lw_v_r, lw_bank_r;
  logic [WA-1:0]                lw_addr_r;
  logic [WORD_W-1:0]            lw_data_r;

  logic                         db_r;
  logic [WA:0]                  iss_r;
  logic                         rp_r;
  logic [WA-1:0]                rk_r;

  logic [NBANK-1:0]             re, we;
  logic [NBANK-1:0][WA-1:0]     raddr;
  logic [NBANK-1:0][WORD_W-1:0] rdata;
  logic [WA-1:0]                s2_word;
  logic [WORD_W-1:0]            base, merged;
  logic                         issue;

  always_comb begin
    s2_word = s2_idx_r[IDX_W-1 -: WA];
    if (lw_v_r && (lw_bank_r == s2_bank_r) && (lw_addr_r == s2_word)) begin
      base = lw_data_r;  // write landed on the edge that captured the stale read
    end else if (wvld_r[s2_bank_r][s2_word]) begin
      base = rdata[s2_bank_r];
    end else begin
      base = '0;
    end
    merged = base | (WORD_W'(1) << s2_idx_r[BIT_W-1:0]);

    // drain waits until the bank's last bit-sets have been written
    issue = busy_r[db_r] && (iss_r < (WA+1)'(WORDS))
            && !(s1_v_r && (s1_bank_r == db_r))
            && !(s2_v_r && (s2_bank_r == db_r))
            && (!rp_r || take);

    for (int b = 0; b < NBANK; b++) begin
      re[b]    = (s1_v_r && (s1_bank_r == 1'(b))) || (issue && (db_r == 1'(b)));
      raddr[b] = (s1_v_r && (s1_bank_r == 1'(b))) ? s1_idx_r[IDX_W-1 -: WA] : iss_r[WA-1:0];
      we[b]    = s2_v_r && (s2_bank_r == 1'(b));
    end

    bank_free     = !busy_r[cur_bank_r];
    wd_pend       = rp_r;
    wd.f          = fld_r[db_r];
    wd.word_index = rk_r;
    wd.data       = (wvld_r[db_r][rk_r] && fld_r[db_r].well_formed) ? rdata[db_r] : '0;
    wd.last       = (rk_r == WA'(WORDS - 1));
  end

  for (genvar g = 0; g < NBANK; g++) begin : g_bank
    scp_ram #(
      .WIDTH(WORD_W),
      .DEPTH(WORDS)
    ) u_ram (
      .clk  (clk),
      .we   (we[g]),
      .waddr(s2_word),
      .wdata(merged),
      .re   (re[g]),
      .raddr(raddr[g]),
      .rdata(rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_bank_r <= 1'b0;
      busy_r     <= '0;
      wvld_r     <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      lw_v_r     <= 1'b0;
      db_r       <= 1'b0;
      iss_r      <= '0;
      rp_r       <= 1'b0;
    end else begin
      s1_v_r    <= evt.vld;
      s1_bank_r <= cur_bank_r;
      s1_idx_r  <= evt.idx;
      s2_v_r    <= s1_v_r;
      s2_bank_r <= s1_bank_r;
      s2_idx_r  <= s1_idx_r;
      lw_v_r    <= s2_v_r;
      lw_bank_r <= s2_bank_r;
      lw_addr_r <= s2_word;
      lw_data_r <= merged;

      if (s2_v_r) begin
        wvld_r[s2_bank_r][s2_word] <= 1'b1;
      end

      if (fin.vld) begin
        busy_r[cur_bank_r] <= 1'b1;
        fld_r[cur_bank_r]  <= fin.f;
        cur_bank_r         <= ~cur_bank_r;
      end

      if (issue) begin
        iss_r <= iss_r + (WA+1)'(1);
        rp_r  <= 1'b1;
        rk_r  <= iss_r[WA-1:0];
      end else if (take) begin
        rp_r <= 1'b0;
      end

      // last word handed on: bank is free and logically cleared
      if (take && (rk_r == WA'(WORDS - 1))) begin
        busy_r[db_r] <= 1'b0;
        wvld_r[db_r] <= '0;
        db_r         <= ~db_r;
        iss_r        <= '0;
      end
    end
  end

endmodule
